// File: hw/rtl/sha1md_pkg.sv
// Shared types, constants and helper functions of the SHA-1 digest block.
`default_nettype none

package sha1md_pkg;

    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_WORDS  = 16;
    localparam int BLOCK_BYTES  = 64;
    localparam int LENGTH_POS   = 56;
    localparam int ROUNDS       = 80;

    localparam logic [5:0] LAST_POS  = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] LEN_POS   = 6'(LENGTH_POS);
    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
    localparam logic [2:0] LAST_WORD  = 3'(DIGEST_WORDS - 1);

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_ADD,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic       byte_wr;
        byte_sel_t  byte_sel;
        logic       count_en;
        logic       work_load;
        logic       round_en;
        logic [6:0] round;
        logic       chain_add;
        logic       msg_clear;
        logic [2:0] out_idx;
    } cmd_t;

    typedef struct packed {
        logic [5:0] pos;
    } status_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sha1_message_digest.sv
// Top level of the SHA-1 digest block: byte stream in, five digest words out.
//
//  channel | dir | tdata (low bit up)  | tuser          | tlast
//  s_      | in  | data_byte[7:0]      | byte_valid     | last_byte
//  m_      | out | digest_word[31:0]   | word_index[2:0]| last_word
//
// One byte transfer per cycle while a block fills; the 64th byte of a block
// starts 80 single-cycle rounds in the datapath, followed by a chain update.
// On a last item, padding writes one byte per cycle up to the block end and
// costs one or two further compressions, then the five words leave one per
// transfer. Input is held off during rounds, padding and output; a stalled
// result holds its word. Reset is synchronous and active low, with no clearing pass.
`default_nettype none

module sha1_message_digest (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tuser,   // byte_valid
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // digest_word[31:0]
    output logic [2:0]       m_tuser,   // word_index[2:0]
    output logic             m_tlast
);
    import sha1md_pkg::*;

    cmd_t    cmd;
    status_t status;

    sha1md_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sha1md_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .status      (status),
        .digest_word (m_tdata)
    );

    assign m_tuser = cmd.out_idx;
    assign m_tlast = cmd.out_idx == LAST_WORD;

endmodule

`default_nettype wire

// File: hw/rtl/sha1md_dp.sv
// Datapath of the SHA-1 digest block: byte packing, schedule window, rounds, chain.
`default_nettype none

module sha1md_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sha1md_pkg::cmd_t  cmd,
    input  wire logic [7:0]        data_byte,
    output sha1md_pkg::status_t    status,
    output logic [31:0]            digest_word
);
    import sha1md_pkg::*;

    logic [31:0] chain_reg [DIGEST_WORDS];
    logic [31:0] work_reg  [DIGEST_WORDS];
    logic [31:0] win_reg   [BLOCK_WORDS];
    logic [23:0] part_reg;
    logic [63:0] count_reg;
    logic [5:0]  pos_reg;

    logic [7:0]  byte_val;
    logic [7:0]  len_byte;
    logic [63:0] len_shift;
    logic [31:0] w_t;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [31:0] b_w;
    logic [31:0] c_w;
    logic [31:0] d_w;

    assign len_shift = count_reg >> {~pos_reg[2:0], 3'b000};
    assign len_byte  = len_shift[7:0];

    always_comb begin
        case (cmd.byte_sel)
            BSEL_DATA: byte_val = data_byte;
            BSEL_MARK: byte_val = PAD_MARK;
            BSEL_LEN:  byte_val = len_byte;
            default:   byte_val = 8'h00;
        endcase
    end

    assign b_w = work_reg[1];
    assign c_w = work_reg[2];
    assign d_w = work_reg[3];

    always_comb begin
        if (cmd.round < 7'd16) begin
            w_t = win_reg[0];
        end else begin
            w_t = rotl(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0], 1);
        end
        if (cmd.round < 7'd20) begin
            f_val = (b_w & c_w) | (~b_w & d_w);
            k_val = K0;
        end else if (cmd.round < 7'd40) begin
            f_val = b_w ^ c_w ^ d_w;
            k_val = K1;
        end else if (cmd.round < 7'd60) begin
            f_val = (b_w & c_w) | (b_w & d_w) | (c_w & d_w);
            k_val = K2;
        end else begin
            f_val = b_w ^ c_w ^ d_w;
            k_val = K3;
        end
        t_val = rotl(work_reg[0], 5) + f_val + work_reg[4] + k_val + w_t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pos_reg   <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                chain_reg[i] <= H_INIT[i];
            end
        end else begin
            if (cmd.byte_wr) begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.count_en) begin
                count_reg <= count_reg + 64'd8;
            end
            if (cmd.chain_add) begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            if (cmd.msg_clear) begin
                count_reg <= '0;
                pos_reg   <= '0;
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    chain_reg[i] <= H_INIT[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.byte_wr) begin
            case (pos_reg[1:0])
                2'd0: part_reg[23:16] <= byte_val;
                2'd1: part_reg[15:8]  <= byte_val;
                2'd2: part_reg[7:0]   <= byte_val;
                default: begin
                    for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                        win_reg[i] <= win_reg[i + 1];
                    end
                    win_reg[BLOCK_WORDS - 1] <= {part_reg, byte_val};
                end
            endcase
        end
        if (cmd.round_en) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[BLOCK_WORDS - 1] <= w_t;
            work_reg[0] <= t_val;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= rotl(work_reg[1], 30);
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3];
        end
        if (cmd.work_load) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                work_reg[i] <= chain_reg[i];
            end
        end
    end

    assign status.pos  = pos_reg;
    assign digest_word = chain_reg[cmd.out_idx];

endmodule

`default_nettype wire

// File: hw/rtl/sha1md_ctrl.sv
// Controller of the SHA-1 digest block: intake, padding, round sequencing, output.
`default_nettype none

module sha1md_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 s_tuser,
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire sha1md_pkg::status_t  status,
    output sha1md_pkg::cmd_t          cmd
);
    import sha1md_pkg::*;

    state_t     state_reg, state_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] idx_reg, idx_next;
    logic       pad_reg, pad_next;
    logic       mark_reg, mark_next;
    logic       lenh_reg, lenh_next;
    logic       final_reg, final_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            round_reg <= '0;
            idx_reg   <= '0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            lenh_reg  <= 1'b0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            lenh_reg  <= lenh_next;
            final_reg <= final_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        lenh_next  = lenh_reg;
        final_next = final_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        cmd.byte_sel = BSEL_ZERO;
        cmd.round    = round_reg;
        cmd.out_idx  = idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        cmd.byte_wr  = 1'b1;
                        cmd.byte_sel = BSEL_DATA;
                        cmd.count_en = 1'b1;
                    end
                    if (s_tuser && status.pos == LAST_POS) begin
                        cmd.work_load = 1'b1;
                        pad_next      = s_tlast;
                        mark_next     = 1'b0;
                        final_next    = 1'b0;
                        state_next    = S_COMP;
                    end else if (s_tlast) begin
                        pad_next   = 1'b1;
                        mark_next  = 1'b0;
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD: begin
                cmd.byte_wr = 1'b1;
                if (!mark_reg) begin
                    cmd.byte_sel = BSEL_MARK;
                    mark_next    = 1'b1;
                    lenh_next    = status.pos < LEN_POS;
                end else if (lenh_reg && status.pos >= LEN_POS) begin
                    cmd.byte_sel = BSEL_LEN;
                end else begin
                    cmd.byte_sel = BSEL_ZERO;
                end
                if (status.pos == LAST_POS) begin
                    cmd.work_load = 1'b1;
                    final_next    = cmd.byte_sel == BSEL_LEN;
                    state_next    = S_COMP;
                end
            end
            S_COMP: begin
                cmd.round_en = 1'b1;
                if (round_reg == LAST_ROUND) begin
                    round_next = '0;
                    state_next = S_ADD;
                end else begin
                    round_next = round_reg + 7'd1;
                end
            end
            S_ADD: begin
                cmd.chain_add = 1'b1;
                if (!pad_reg) begin
                    state_next = S_IDLE;
                end else if (final_reg) begin
                    state_next = S_OUT;
                end else begin
                    lenh_next  = 1'b1;
                    state_next = S_PAD;
                end
            end
            S_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (idx_reg == LAST_WORD) begin
                        cmd.msg_clear = 1'b1;
                        idx_next      = '0;
                        pad_next      = 1'b0;
                        mark_next     = 1'b0;
                        lenh_next     = 1'b0;
                        final_next    = 1'b0;
                        state_next    = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= LAST_ROUND)
        else $error("round counter beyond last round");

    a_block_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COMP || state_reg == S_ADD || state_reg == S_OUT) |->
            status.pos == 6'd0)
        else $error("compression or output with a partly filled block");

    a_out_after_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && $past(state_reg) != S_OUT) |-> $past(state_reg) == S_ADD)
        else $error("digest output not preceded by a chain update");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= LAST_WORD)
        else $error("digest word index out of range");

    a_final_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        final_reg |-> pad_reg && mark_reg)
        else $error("final block flagged outside padding");
`endif

endmodule

`default_nettype wire

// File: tb/sha1_message_digest_tb.sv
// Self-checking bench for the SHA-1 digest block, with a local digest model and a scoreboard.
`timescale 1ns / 100ps

module sha1_message_digest_tb;

    import sha1md_pkg::*;

    localparam int ITEM_TARGET   = 330;
    localparam int CALM_FROM     = 290;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 200;
    localparam int PRINT_LIMIT   = 30;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  index;
        logic        is_last;
    } digest_beat_t;

    class digest_scoreboard;
        logic [31:0]  chain [DIGEST_WORDS];
        logic [31:0]  sched [BLOCK_WORDS];
        logic [63:0]  bit_total;
        logic [5:0]   fill_pos;
        digest_beat_t pending_words [$];
        int           errors;
        int           words_checked;
        int           messages;

        function new();
            errors        = 0;
            words_checked = 0;
            messages      = 0;
            clear_message();
        endfunction

        function void clear_message();
            for (int i = 0; i < DIGEST_WORDS; i++) chain[i] = H_INIT[i];
            for (int i = 0; i < BLOCK_WORDS; i++) sched[i] = '0;
            bit_total = '0;
            fill_pos  = '0;
        endfunction

        function logic [31:0] rol(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress();
            logic [31:0] a, b, c, d, e, f, k, w, t;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int r = 0; r < ROUNDS; r++) begin
                if (r >= 16)
                    sched[r & 15] = rol(sched[(r + 13) & 15] ^ sched[(r + 8) & 15]
                                        ^ sched[(r + 2) & 15] ^ sched[r & 15], 1);
                w = sched[r & 15];
                if (r < 20) begin
                    f = (b & c) | (~b & d);
                    k = K0;
                end else if (r < 40) begin
                    f = b ^ c ^ d;
                    k = K1;
                end else if (r < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K2;
                end else begin
                    f = b ^ c ^ d;
                    k = K3;
                end
                t = rol(a, 5) + f + e + k + w;
                e = d;
                d = c;
                c = rol(b, 30);
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // pack the byte into the schedule, compress whenever the block wraps
        function void push_byte(logic [7:0] b);
            logic [31:0] shifted;
            shifted = {24'h0, b} << (8 * (3 - int'(fill_pos[1:0])));
            if (fill_pos[1:0] == 2'd0)
                sched[fill_pos[5:2]] = shifted;
            else
                sched[fill_pos[5:2]] = sched[fill_pos[5:2]] | shifted;
            fill_pos = fill_pos + 6'd1;
            if (fill_pos == 6'd0)
                compress();
        endfunction

        function void note_transfer(logic [7:0] data, logic valid, logic last);
            logic [63:0] len;
            if (valid) begin
                push_byte(data);
                bit_total += 64'd8;
            end
            if (last) begin
                len = bit_total;
                push_byte(PAD_MARK);
                while (fill_pos != LEN_POS) push_byte(8'h00);
                for (int i = 0; i < 8; i++) push_byte(len[63 - 8 * i -: 8]);
                for (int i = 0; i < DIGEST_WORDS; i++)
                    pending_words.push_back('{chain[i], 3'(i), 3'(i) == LAST_WORD});
                messages++;
                clear_message();
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t mismatch: %s", $time, what);
        endtask

        task check_word(logic [31:0] value, logic [2:0] index, logic is_last);
            digest_beat_t want;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word %h index %0d", value, index));
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (value !== want.value)
                report($sformatf("word %0d is %h, want %h", want.index, value, want.value));
            if (index !== want.index)
                report($sformatf("index is %0d, want %0d", index, want.index));
            if (is_last !== want.is_last)
                report($sformatf("last flag on word %0d is %b, want %b",
                                 want.index, is_last, want.is_last));
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // data_byte[7:0]
    logic        s_tuser  = 1'b0;    // byte_valid
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // digest_word[31:0]
    logic [2:0]  m_tuser;            // word_index[2:0]
    logic        m_tlast;

    digest_scoreboard digests = new();
    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int bytes_sent = 0;
    int items_sent = 0;
    int stall_left = 0;

    sha1_message_digest u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    task automatic put_item(logic [7:0] data, logic valid, logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= valid;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        digests.note_transfer(data, valid, last);
        items_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic send_message(int len, bit empty_end);
        for (int i = 0; i < len; i++) begin
            if (!calm && $urandom_range(0, 9) == 0)
                put_item(8'($urandom), 1'b0, 1'b0);
            put_item(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
            bytes_sent++;
        end
        if (empty_end || len == 0)
            put_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (digests.pending() != 0);
    endtask

    // result side: check, then choose tready for the next cycle
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready)
                digests.check_word(m_tdata, m_tuser, m_tlast);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
                m_tready   <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d quiet cycles", QUIET_LIMIT);
        $display("[sha1_message_digest] ERROR");
        $finish;
    end

    initial begin
        int fixed_len [3] = '{55, 56, 64};
        int sel;
        int len;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        put_item(8'h00, 1'b0, 1'b0);
        put_item(8'h5A, 1'b0, 1'b1);
        put_item(8'h00, 1'b1, 1'b1);
        put_item(8'hFF, 1'b1, 1'b1);
        put_item(8'hA5, 1'b1, 1'b0);
        put_item(8'h3C, 1'b0, 1'b1);
        put_item(8'hFF, 1'b0, 1'b0);
        put_item(8'h61, 1'b1, 1'b0);
        put_item(8'h62, 1'b1, 1'b0);
        put_item(8'h63, 1'b1, 1'b1);
        put_item(8'h80, 1'b1, 1'b0);
        put_item(8'h7F, 1'b1, 1'b0);
        put_item(8'hC3, 1'b0, 1'b1);

        // exact fit, long tail and whole block before padding
        foreach (fixed_len[i])
            send_message(fixed_len[i], $urandom_range(0, 2) == 0);

        hold_req = 1'b1;
        repeat (4) send_message($urandom_range(0, 6), $urandom_range(0, 2) == 0);
        drain();

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= CALM_FROM)
                calm = 1'b1;
            sel = $urandom_range(0, 9);
            if (sel < 7)
                len = $urandom_range(0, 8);
            else if (sel < 9)
                len = $urandom_range(50, 66);
            else
                len = $urandom_range(65, 130);
            send_message(len, $urandom_range(0, 2) == 0);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d messages, %0d random bytes, incl. exact-fit, long-tail and multi-block",
                 digests.messages, bytes_sent);
        $display("%0d digest words checked under random stalls, %0d mismatches",
                 digests.words_checked, digests.errors);
        if (digests.errors == 0)
            $display("[sha1_message_digest] OK");
        else
            $display("[sha1_message_digest] ERROR");
        $finish;
    end

endmodule

// File: sha1_message_digest.f
hw/rtl/sha1md_pkg.sv
hw/rtl/sha1md_dp.sv
hw/rtl/sha1md_ctrl.sv
hw/rtl/sha1_message_digest.sv
tb/sha1_message_digest_tb.sv
